// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// consequent checked on the edge after the trigger
`define ASSERT_NEXT(label, clk_sig, rst_sig, trig, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mbrd_pkg.sv
`timescale 1ns / 1ps
package mbrd_pkg;

    localparam int RESPONSE_MAX_DEFAULT = 9;
    localparam int MIN_RESPONSE         = 7;
    localparam int HEAD_BYTES           = 5;
    localparam int FRAME_LEN            = 8;
    localparam int FRAME_IDX_W          = $clog2(FRAME_LEN);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] ERROR_VALUE = 16'hFFFF;
    localparam logic [15:0] READ_COUNT  = 16'h0001;
    localparam logic [7:0]  BYTE_COUNT  = 8'd2;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;
    localparam logic [7:0] FUNCTION_CODE_RESET  = 8'd3;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_RX_BYTE = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_SHORT      = 3'd1,
        STATUS_BAD_HEADER = 3'd2,
        STATUS_BAD_COUNT  = 3'd3,
        STATUS_BAD_CRC    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_FUNCTION_CODE  = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic [7:0] data;
    } rx_ctrl_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] value;
    } verdict_t;

    // one byte of reflected crc-16, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/modbus_read_register_master.sv
`timescale 1ns / 1ps
// path: an accepted item is held in the input register; frame bytes and verdicts
//   go one per cycle through the single result register while it is not stalled
// throughput: one received byte per cycle; a request holds the input to its last
//   frame byte
// reset: byte count 0, crc 0xFFFF, address 1, function 3; stored bytes not cleared
module modbus_read_register_master #(
    parameter int RESPONSE_MAX = mbrd_pkg::RESPONSE_MAX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] reg_address,
    input  logic [7:0]  rx_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [15:0] value,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = mbrd_pkg::FRAME_IDX_W;
    localparam logic [IDX_W-1:0] FRAME_LAST   = IDX_W'(mbrd_pkg::FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] FRAME_CRC_LO = IDX_W'(mbrd_pkg::FRAME_LEN - 2);
    localparam logic [IDX_W-1:0] IDX_ONE      = IDX_W'(1);

    logic              item_valid_reg;
    logic [1:0]        kind_reg;
    logic [15:0]       reg_address_reg;
    logic [7:0]        rx_byte_reg;

    logic [IDX_W-1:0]  frame_idx_reg;
    logic [IDX_W-1:0]  frame_idx_next;
    logic [15:0]       tx_crc_reg;
    logic [15:0]       tx_crc_next;

    logic [7:0]        device_address_reg;
    logic [7:0]        function_code_reg;

    logic              result_valid_reg;
    logic              tx_valid_reg;
    logic [7:0]        tx_byte_reg;
    logic              last_reg;
    logic              done_res_reg;
    logic [2:0]        status_reg;
    logic [15:0]       value_reg;

    logic              out_free;
    logic              emit_frame;
    logic              emit_verdict;
    logic              item_done;
    logic              load;
    logic [7:0]        frame_byte;

    mbrd_pkg::rx_ctrl_t rx_ctrl;
    mbrd_pkg::verdict_t verdict;

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = item_valid_reg && !item_done;
    assign load       = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        case (frame_idx_reg)
            3'd0:    frame_byte = device_address_reg;
            3'd1:    frame_byte = function_code_reg;
            3'd2:    frame_byte = reg_address_reg[15:8];
            3'd3:    frame_byte = reg_address_reg[7:0];
            3'd4:    frame_byte = mbrd_pkg::READ_COUNT[15:8];
            3'd5:    frame_byte = mbrd_pkg::READ_COUNT[7:0];
            3'd6:    frame_byte = tx_crc_reg[7:0];
            default: frame_byte = tx_crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        emit_frame   = 1'b0;
        emit_verdict = 1'b0;
        item_done    = 1'b0;
        rx_ctrl      = '0;
        rx_ctrl.data = rx_byte_reg;
        if (item_valid_reg)
        begin
            case (mbrd_pkg::kind_t'(kind_reg))
                mbrd_pkg::KIND_REQUEST:
                begin
                    emit_frame    = out_free;
                    item_done     = out_free && (frame_idx_reg == FRAME_LAST);
                    rx_ctrl.clear = out_free;
                end
                mbrd_pkg::KIND_RX_BYTE:
                begin
                    item_done    = 1'b1;
                    rx_ctrl.push = 1'b1;
                end
                mbrd_pkg::KIND_END:
                begin
                    emit_verdict = out_free;
                    item_done    = out_free;
                end
                default:
                begin
                    item_done = 1'b1;
                end
            endcase
        end
    end

    // running crc over the six header bytes, held while the crc bytes go out
    always_comb
    begin
        frame_idx_next = frame_idx_reg;
        tx_crc_next    = tx_crc_reg;
        if (emit_frame)
        begin
            frame_idx_next = (frame_idx_reg == FRAME_LAST) ? '0 : frame_idx_reg + IDX_ONE;
            if (frame_idx_reg == '0)
            begin
                tx_crc_next = mbrd_pkg::crc16_byte(mbrd_pkg::CRC_INIT, frame_byte);
            end
            else if (frame_idx_reg < FRAME_CRC_LO)
            begin
                tx_crc_next = mbrd_pkg::crc16_byte(tx_crc_reg, frame_byte);
            end
        end
    end

    mbrd_rx #(
        .RESPONSE_MAX (RESPONSE_MAX)
    ) u_rx (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (rx_ctrl),
        .device_address (device_address_reg),
        .function_code  (function_code_reg),
        .verdict        (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            frame_idx_reg      <= '0;
            result_valid_reg   <= 1'b0;
            device_address_reg <= mbrd_pkg::DEVICE_ADDRESS_RESET;
            function_code_reg  <= mbrd_pkg::FUNCTION_CODE_RESET;
        end
        else
        begin
            if (load)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            frame_idx_reg <= frame_idx_next;
            if (out_free)
            begin
                result_valid_reg <= emit_frame || emit_verdict;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (mbrd_pkg::cfg_index_t'(cfg_index))
                    mbrd_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                    mbrd_pkg::CFG_FUNCTION_CODE:  function_code_reg  <= cfg_data;
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg        <= kind;
            reg_address_reg <= reg_address;
            rx_byte_reg     <= rx_byte;
        end
        tx_crc_reg <= tx_crc_next;
        if (emit_frame)
        begin
            tx_valid_reg <= 1'b1;
            tx_byte_reg  <= frame_byte;
            last_reg     <= (frame_idx_reg == FRAME_LAST);
            done_res_reg <= 1'b0;
            status_reg   <= mbrd_pkg::STATUS_OK;
            value_reg    <= '0;
        end
        else if (emit_verdict)
        begin
            tx_valid_reg <= 1'b0;
            tx_byte_reg  <= '0;
            last_reg     <= 1'b1;
            done_res_reg <= 1'b1;
            status_reg   <= verdict.status;
            value_reg    <= verdict.value;
        end
    end

    assign result_valid = result_valid_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign last         = last_reg;
    assign done_res     = done_res_reg;
    assign status       = status_reg;
    assign value        = value_reg;

endmodule

// File: rtl/mbrd_rx.sv
`timescale 1ns / 1ps
module mbrd_rx #(
    parameter int RESPONSE_MAX = mbrd_pkg::RESPONSE_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbrd_pkg::rx_ctrl_t ctrl,
    input  logic [7:0]         device_address,
    input  logic [7:0]         function_code,
    output mbrd_pkg::verdict_t verdict
);

    localparam int COUNT_W = $clog2(RESPONSE_MAX + 1);
    localparam int HEAD_W  = $clog2(mbrd_pkg::HEAD_BYTES);

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(RESPONSE_MAX);
    localparam logic [COUNT_W-1:0] COUNT_MIN  = COUNT_W'(mbrd_pkg::MIN_RESPONSE);
    localparam logic [COUNT_W-1:0] COUNT_HEAD = COUNT_W'(mbrd_pkg::HEAD_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_LAG  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

    // only the header bytes and the two newest bytes are ever checked
    logic [7:0]         head_reg [mbrd_pkg::HEAD_BYTES];
    logic [7:0]         tail1_reg;
    logic [7:0]         tail0_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic               store;

    assign store = ctrl.push && (count_reg < COUNT_FULL);

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            crc_next   = mbrd_pkg::CRC_INIT;
        end
        else if (store)
        begin
            count_next = count_reg + COUNT_ONE;
            // crc lags two bytes behind the store
            if (count_reg >= COUNT_LAG)
            begin
                crc_next = mbrd_pkg::crc16_byte(crc_reg, tail0_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= mbrd_pkg::CRC_INIT;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store && !ctrl.clear)
        begin
            if (count_reg < COUNT_HEAD)
            begin
                head_reg[count_reg[HEAD_W-1:0]] <= ctrl.data;
            end
            tail0_reg <= tail1_reg;
            tail1_reg <= ctrl.data;
        end
    end

    always_comb
    begin
        verdict.value = mbrd_pkg::ERROR_VALUE;
        if (count_reg < COUNT_MIN)
        begin
            verdict.status = mbrd_pkg::STATUS_SHORT;
        end
        else if (head_reg[0] != device_address || head_reg[1] != function_code)
        begin
            verdict.status = mbrd_pkg::STATUS_BAD_HEADER;
        end
        else if (head_reg[2] != mbrd_pkg::BYTE_COUNT)
        begin
            verdict.status = mbrd_pkg::STATUS_BAD_COUNT;
        end
        else if ({tail1_reg, tail0_reg} == crc_reg)
        begin
            verdict.status = mbrd_pkg::STATUS_OK;
            verdict.value  = {head_reg[3], head_reg[4]};
        end
        else
        begin
            verdict.status = mbrd_pkg::STATUS_BAD_CRC;
        end
    end

endmodule

// File: rtl/mbrd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic        tx_valid,
    input logic [7:0]  tx_byte,
    input logic        last,
    input logic        done_res,
    input logic [2:0]  status,
    input logic [15:0] value
);

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(tx_byte) && $stable(status) && $stable(value) && $stable(last), "stalled result changed")

    // every result is either a frame byte or a verdict
    `ASSERT_CLK(a_result_kind, clk, rst_n, result_valid |-> (tx_valid != done_res), "result is neither frame byte nor verdict")

    // a verdict always closes its transaction
    `ASSERT_CLK(a_verdict_last, clk, rst_n, result_valid && done_res |-> last && tx_byte == 8'h00, "verdict without last")

    // failed verdicts carry the error value
    `ASSERT_CLK(a_error_value, clk, rst_n, result_valid && done_res && status != mbrd_pkg::STATUS_OK |-> value == mbrd_pkg::ERROR_VALUE, "error verdict with register value")

endmodule

bind modbus_read_register_master mbrd_checker u_mbrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .last         (last),
    .done_res     (done_res),
    .status       (status),
    .value        (value)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    import mbrd_pkg::*;

    localparam int ITEM_TARGET   = 380;
    localparam int RAND_PHASES   = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int RESP_BUF      = 12;

    // kind with no meaning and register slots past the list, all ignored by the block
    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] value;
    } mb_out_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CRC_LO,
        ROW_CRC_HI,
        ROW_CFG
    } row_op_t;

    // for ROW_CFG the register index sits in arg[1:0]
    typedef struct packed {
        row_op_t     op;
        logic [1:0]  kind;
        logic [15:0] arg;
        logic [7:0]  data;
        logic        has_exp;
        logic [2:0]  exp_status;
        logic [15:0] exp_value;
    } row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    logic [1:0]  kind         = KIND_REQUEST;
    logic [15:0] reg_address  = 16'h0000;
    logic [7:0]  rx_byte      = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] value;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = CFG_DEVICE_ADDRESS;
    logic [7:0]  cfg_data     = 8'h00;

    // shadow of the master's registers and receive buffer
    logic [7:0]  p_dev_addr   = DEVICE_ADDRESS_RESET;
    logic [7:0]  p_func_code  = FUNCTION_CODE_RESET;
    logic [7:0]  p_rx_mem [0:RESPONSE_MAX_DEFAULT-1];
    int          p_rx_cnt     = 0;
    logic [15:0] p_rx_crc     = CRC_INIT;

    mb_out_t     tx_and_verdict_q [$];
    row_t        dir_rows [$];
    row_t        rw;
    mb_out_t     typed_out;
    logic [15:0] crc_tmp;

    int          fail_count    = 0;
    int          items_sent    = 0;
    int          burst_left    = 0;
    int          goal          = 0;
    logic        pressure_armed = 1'b0;
    logic        pressure_done  = 1'b0;
    int          hold_left     = 0;
    int          mode_left     = 0;
    int          stall_pct     = 0;

    modbus_read_register_master u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .reg_address  (reg_address),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .last         (last),
        .done_res     (done_res),
        .status       (status),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        repeat (8)
        begin
            c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // crc over the first n buffered bytes
    function automatic logic [15:0] crc_of_stored(input int n);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < n; i++)
        begin
            c = crc16_step(c, p_rx_mem[i]);
        end
        return c;
    endfunction

    function automatic row_t mk_row(input row_op_t op, input logic [1:0] k,
                                    input logic [15:0] arg, input logic [7:0] d,
                                    input logic has_exp, input logic [2:0] st,
                                    input logic [15:0] v);
        row_t r;
        r.op         = op;
        r.kind       = k;
        r.arg        = arg;
        r.data       = d;
        r.has_exp    = has_exp;
        r.exp_status = st;
        r.exp_value  = v;
        return r;
    endfunction

    task automatic predict_frame_or_verdict(input logic [1:0] k, input logic [15:0] ra,
                                            input logic [7:0] rb, input bit emit);
        logic [7:0]  frame [0:FRAME_LEN-1];
        logic [15:0] crc;
        logic [15:0] got;
        mb_out_t     r;
        case (k)
            KIND_REQUEST:
            begin
                frame[0] = p_dev_addr;
                frame[1] = p_func_code;
                frame[2] = ra[15:8];
                frame[3] = ra[7:0];
                frame[4] = READ_COUNT[15:8];
                frame[5] = READ_COUNT[7:0];
                crc = CRC_INIT;
                for (int i = 0; i < 6; i++)
                begin
                    crc = crc16_step(crc, frame[i]);
                end
                frame[6] = crc[7:0];
                frame[7] = crc[15:8];
                for (int i = 0; i < FRAME_LEN; i++)
                begin
                    r = '0;
                    r.tx_valid = 1'b1;
                    r.tx_byte  = frame[i];
                    r.last     = (i == FRAME_LEN - 1);
                    if (emit) tx_and_verdict_q.push_back(r);
                end
                p_rx_cnt = 0;
                p_rx_crc = CRC_INIT;
            end
            KIND_RX_BYTE:
            begin
                if (p_rx_cnt < RESPONSE_MAX_DEFAULT)
                begin
                    p_rx_mem[p_rx_cnt] = rb;
                    // crc trails the buffer by two bytes
                    if (p_rx_cnt >= 2) p_rx_crc = crc16_step(p_rx_crc, p_rx_mem[p_rx_cnt - 2]);
                    p_rx_cnt++;
                end
            end
            KIND_END:
            begin
                r = '0;
                r.last     = 1'b1;
                r.done_res = 1'b1;
                r.value    = ERROR_VALUE;
                if (p_rx_cnt < MIN_RESPONSE)
                    r.status = STATUS_SHORT;
                else if (p_rx_mem[0] != p_dev_addr || p_rx_mem[1] != p_func_code)
                    r.status = STATUS_BAD_HEADER;
                else if (p_rx_mem[2] != BYTE_COUNT)
                    r.status = STATUS_BAD_COUNT;
                else
                begin
                    got = {p_rx_mem[p_rx_cnt - 1], p_rx_mem[p_rx_cnt - 2]};
                    if (got == p_rx_crc)
                    begin
                        r.status = STATUS_OK;
                        r.value  = {p_rx_mem[3], p_rx_mem[4]};
                    end
                    else
                    begin
                        r.status = STATUS_BAD_CRC;
                    end
                end
                if (emit) tx_and_verdict_q.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // offer one item in bursts with random gaps, return at the accepting edge
    task automatic send_item(input logic [1:0] k, input logic [15:0] ra,
                             input logic [7:0] rb, input bit emit);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid  <= 1'b1;
        kind        <= k;
        reg_address <= ra;
        rx_byte     <= rb;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_frame_or_verdict(k, ra, rb, emit);
        if (k != KIND_NONE) items_sent++;
    endtask

    // let all outstanding results drain before touching the registers
    task automatic wait_idle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (tx_and_verdict_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_DEVICE_ADDRESS: p_dev_addr = d;
            CFG_FUNCTION_CODE:  p_func_code = d;
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one request and response exchange, mostly well formed
    task automatic play_exchange();
        int          mode;
        int          n;
        int          pos;
        int          bitpos;
        logic [7:0]  resp [0:RESP_BUF-1];
        logic [15:0] crc;
        logic [15:0] ra;
        mode = $urandom_range(0, 99);
        if (mode < 95)
        begin
            if ($urandom_range(0, 9) == 0)
                ra = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                ra = 16'($urandom_range(0, 16'hFFFF));
            send_item(KIND_REQUEST, ra, 8'($urandom_range(0, 255)), 1'b1);
        end
        for (int i = 0; i < RESP_BUF; i++)
        begin
            resp[i] = 8'($urandom_range(0, 255));
        end
        if (mode < 75)
        begin
            n = ($urandom_range(0, 9) < 8) ? MIN_RESPONSE : $urandom_range(8, 9);
            resp[0] = p_dev_addr;
            resp[1] = p_func_code;
            resp[2] = BYTE_COUNT;
            if ($urandom_range(0, 7) == 0)
                {resp[3], resp[4]} = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            crc = CRC_INIT;
            for (int i = 0; i < n - 2; i++)
            begin
                crc = crc16_step(crc, resp[i]);
            end
            resp[n - 2] = crc[7:0];
            resp[n - 1] = crc[15:8];
            // single bit error somewhere in the frame
            if (mode >= 60)
            begin
                pos = $urandom_range(0, n - 1);
                bitpos = $urandom_range(0, 7);
                resp[pos][bitpos] = ~resp[pos][bitpos];
            end
            // trailing bytes past a full buffer
            if (n == RESPONSE_MAX_DEFAULT && $urandom_range(0, 2) == 0)
                n = n + $urandom_range(1, 3);
        end
        else if (mode < 85)
        begin
            n = $urandom_range(0, MIN_RESPONSE - 1);
            resp[0] = p_dev_addr;
            resp[1] = p_func_code;
            resp[2] = BYTE_COUNT;
        end
        else
        begin
            n = $urandom_range(0, RESP_BUF);
            if ($urandom_range(0, 1) == 1)
            begin
                resp[0] = p_dev_addr;
                resp[1] = p_func_code;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(KIND_NONE, 16'($urandom_range(0, 16'hFFFF)),
                          8'($urandom_range(0, 255)), 1'b1);
            send_item(KIND_RX_BYTE, 16'($urandom_range(0, 16'hFFFF)), resp[i], 1'b1);
        end
        if ($urandom_range(0, 19) != 0)
            send_item(KIND_END, 16'($urandom_range(0, 16'hFFFF)),
                      8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 9) == 0)
            send_item(KIND_END, 16'($urandom_range(0, 16'hFFFF)),
                      8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        mb_out_t want;
        if (tx_and_verdict_q.size() == 0)
        begin
            $display("%0t: unexpected transaction, expected none, got tx_valid=%0d tx_byte=%0h",
                     $time, tx_valid, tx_byte);
            $display("    last=%0d done_res=%0d status=%0d value=%0h",
                     last, done_res, status, value);
            fail_count++;
        end
        else
        begin
            want = tx_and_verdict_q.pop_front();
            compare_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid));
            compare_field("tx_byte", 16'(want.tx_byte), 16'(tx_byte));
            compare_field("last", 16'(want.last), 16'(last));
            compare_field("done_res", 16'(want.done_res), 16'(done_res));
            compare_field("status", 16'(want.status), 16'(status));
            compare_field("value", want.value, value);
        end
    endtask

    // result side: check each transaction, stall in modes of random length
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) check_result();
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (pressure_armed && !pressure_done && result_valid)
        begin
            // long back-pressure so the input side backs up
            pressure_done <= 1'b1;
            hold_left     <= LONG_HOLD;
            result_stall  <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left <= $urandom_range(4, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 60;
                    default: stall_pct <= 90;
                endcase
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        // receiver empty right after reset
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'h0000, 8'h00, 1'b1, STATUS_SHORT, ERROR_VALUE));
        // good response with no request in front of it
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'hFFFF, 8'h01, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h03, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'hA5A5, 8'h02, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h5A5A, 8'hFF, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_CRC_LO, KIND_RX_BYTE, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_CRC_HI, KIND_RX_BYTE, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        // second end repeats the verdict
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'hFFFF, 8'hFF, 1'b0, STATUS_OK, 16'h0));
        // fill the buffer, then one byte that is dropped
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h55, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'hAA, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_NONE, 16'hFFFF, 8'hFF, 1'b0, STATUS_OK, 16'h0));
        // same buffer judged against other address and function settings
        dir_rows.push_back(mk_row(ROW_CFG, 2'd0, CFG_DEVICE_ADDRESS, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'h0000, 8'h00, 1'b1, STATUS_BAD_HEADER, ERROR_VALUE));
        dir_rows.push_back(mk_row(ROW_CFG, 2'd0, CFG_DEVICE_ADDRESS, 8'h01, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_CFG, 2'd0, CFG_FUNCTION_CODE, 8'hFF, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'h0000, 8'h00, 1'b1, STATUS_BAD_HEADER, ERROR_VALUE));
        dir_rows.push_back(mk_row(ROW_CFG, 2'd0, CFG_FUNCTION_CODE, 8'h03, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_CFG, 2'd0, CFG_SPARE_A, 8'h5A, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_CFG, 2'd0, CFG_SPARE_B, 8'hA5, 1'b0, STATUS_OK, 16'h0));
        // request, then a response with a zero byte count
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_REQUEST, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h01, 1'b0, STATUS_OK, 16'h0));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h03, 1'b0, STATUS_OK, 16'h0));
        for (int i = 0; i < 5; i++)
        begin
            dir_rows.push_back(mk_row(ROW_ITEM, KIND_RX_BYTE, 16'h0000, 8'h00, 1'b0, STATUS_OK, 16'h0));
        end
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_END, 16'h0000, 8'h00, 1'b1, STATUS_BAD_COUNT, ERROR_VALUE));
        dir_rows.push_back(mk_row(ROW_ITEM, KIND_REQUEST, 16'hFFFF, 8'hFF, 1'b0, STATUS_OK, 16'h0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
        begin
            rw = dir_rows[i];
            case (rw.op)
                ROW_CFG:
                begin
                    wait_idle();
                    write_reg(rw.arg[1:0], rw.data);
                end
                ROW_CRC_LO:
                begin
                    crc_tmp = crc_of_stored(p_rx_cnt);
                    send_item(KIND_RX_BYTE, rw.arg, crc_tmp[7:0], 1'b1);
                end
                ROW_CRC_HI:
                begin
                    crc_tmp = crc_of_stored(p_rx_cnt - 1);
                    send_item(KIND_RX_BYTE, rw.arg, crc_tmp[15:8], 1'b1);
                end
                default:
                begin
                    send_item(rw.kind, rw.arg, rw.data, !rw.has_exp);
                    if (rw.has_exp)
                    begin
                        typed_out          = '0;
                        typed_out.last     = 1'b1;
                        typed_out.done_res = 1'b1;
                        typed_out.status   = rw.exp_status;
                        typed_out.value    = rw.exp_value;
                        tx_and_verdict_q.push_back(typed_out);
                    end
                end
            endcase
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
                    write_reg(CFG_FUNCTION_CODE, 8'h00);
                end
                1:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'h00);
                    write_reg(CFG_FUNCTION_CODE, 8'hFF);
                end
                3:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, DEVICE_ADDRESS_RESET);
                    write_reg(CFG_FUNCTION_CODE, FUNCTION_CODE_RESET);
                    pressure_armed = 1'b1;
                end
                default:
                begin
                    write_reg(CFG_DEVICE_ADDRESS, 8'($urandom_range(0, 255)));
                    write_reg(CFG_FUNCTION_CODE, 8'($urandom_range(0, 255)));
                end
            endcase
            goal = items_sent + ITEM_TARGET / RAND_PHASES;
            while (items_sent < goal) play_exchange();
        end

        wait_idle();
        if (fail_count == 0)
            $display("[modbus_read_register_master] OK");
        else
            $display("[modbus_read_register_master] ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[modbus_read_register_master] ERROR");
        $finish;
    end

endmodule
